FILE: hw/rtl/fhp_pkg.sv
// ----------------------------------------------------------------------------
// fhp_pkg
// Shared types, codes and helpers of the frame header parser.
// ----------------------------------------------------------------------------
package fhp_pkg;

  localparam int FRAME_CODES = 256;
  localparam int MAX_STREAMS = 16;
  localparam int CODE_W      = $clog2(FRAME_CODES);
  localparam int STREAM_W    = $clog2(MAX_STREAMS);

  localparam logic [1:0] MODE_BYTE        = 2'd0;
  localparam logic [1:0] MODE_CODE_LOAD   = 2'd1;
  localparam logic [1:0] MODE_STREAM_LOAD = 2'd2;

  localparam logic [1:0] KIND_FRAME      = 2'd0;
  localparam logic [1:0] KIND_NON_FRAME  = 2'd1;
  localparam logic [1:0] KIND_BAD_STREAM = 2'd2;

  localparam logic [7:0]  NOT_FRAME_BYTE = 8'h4E;
  localparam logic [7:0]  VARINT_CONT    = 8'h80;
  localparam logic [6:0]  VARINT_DATA    = 7'h7F;
  localparam logic [31:0] LEN_MAX        = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         data_byte;
    logic [7:0]         entry_index;
    logic [2:0]         entry_flags;
    logic [4:0]         entry_stream_plus_one;
    logic [15:0]        entry_multiplier;
    logic [16:0]        entry_size_base;
    logic signed [15:0] entry_pts_step;
    logic [3:0]         entry_extra_fields;
    logic [5:0]         stream_shift;
    logic [63:0]        stream_start_pts;
  } fhp_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  start_code;
    logic [3:0]  stream_id;
    logic [63:0] frame_pts;
    logic [31:0] frame_length;
    logic        is_keyframe;
  } fhp_out_t;

  typedef struct packed {
    logic [2:0]  flags;
    logic [4:0]  stream_plus_one;
    logic [15:0] multiplier;
    logic [16:0] size_base;
    logic [15:0] pts_step;
    logic [3:0]  extra_fields;
  } code_entry_t;

  typedef struct packed {
    logic    go;
    fhp_in_t item;
  } fhp_step_t;

  typedef struct packed {
    logic     valid;
    fhp_out_t data;
  } fhp_res_t;

  function automatic code_entry_t to_entry(fhp_in_t it);
    code_entry_t e;
    e.flags           = it.entry_flags;
    e.stream_plus_one = it.entry_stream_plus_one;
    e.multiplier      = it.entry_multiplier;
    e.size_base       = it.entry_size_base;
    e.pts_step        = it.entry_pts_step;
    e.extra_fields    = it.entry_extra_fields;
    return e;
  endfunction

endpackage

FILE: hw/rtl/frame_header_parser.sv
// ----------------------------------------------------------------------------
// frame_header_parser
// Frame header parser for a byte-oriented container stream.
// ----------------------------------------------------------------------------
// Takes one item per cycle (stream byte, code-table load or stream-table load).
// The edge that accepts an item registers it and reads the 256-entry code
// table at its byte value; the parse step then runs into the result register
// once that register is free or being taken, and any result it yields is offered from there.
// Items follow back to back while results are taken; a result left waiting in
// the result register holds the item behind it and stalls the input.
module frame_header_parser import fhp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  fhp_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output fhp_out_t out_data_o
);

  logic        s1_valid_q;
  fhp_in_t     s1_q;
  code_entry_t rd_q;
  code_entry_t code_mem [FRAME_CODES];
  logic        in_acc, go;
  logic        out_valid_q;
  fhp_out_t    out_q;
  fhp_step_t   step;
  fhp_res_t    res;

  assign go         = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || go;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.mode == MODE_CODE_LOAD) begin
      code_mem[in_data_i.entry_index] <= to_entry(in_data_i);
    end
    if (in_acc) begin
      rd_q <= code_mem[in_data_i.data_byte];
      s1_q <= in_data_i;
    end
    if (go && res.valid) out_q <= res.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) s1_valid_q <= 1'b1;
      else if (go) s1_valid_q <= 1'b0;
      if (go && res.valid) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign step.go   = go;
  assign step.item = s1_q;

  fhp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .rd_entry_i (rd_q),
    .res_o      (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a blocked result");

  a_go_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && res.valid |=> out_valid_o && out_data_o == $past(res.data))
    else $error("result not captured");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != KIND_FRAME |->
      out_data_o.frame_pts == '0 && out_data_o.frame_length == '0)
    else $error("rejected header carries frame fields");

endmodule

FILE: hw/rtl/fhp_parser.sv
// ----------------------------------------------------------------------------
// fhp_parser
// Header parse step: varint assembly, phase sequencing, stream tables,
// pts rebuild and length computation for one item per cycle while step_i.go is set.
// ----------------------------------------------------------------------------
module fhp_parser import fhp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fhp_step_t   step_i,
  input  code_entry_t rd_entry_i,
  output fhp_res_t    res_o
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_STREAM = 3'd1;
  localparam logic [2:0] PH_PTS    = 3'd2;
  localparam logic [2:0] PH_SIZE   = 3'd3;
  localparam logic [2:0] PH_EXTRA  = 3'd4;

  logic [2:0]          phase_q, phase_d;
  logic [63:0]         acc_q, acc_d;
  logic [CODE_W-1:0]   code_q, code_d;
  logic [STREAM_W-1:0] stream_q, stream_d;
  logic [63:0]         pend_pts_q, pend_pts_d;
  logic [63:0]         pend_lsb_q, pend_lsb_d;
  logic [3:0]          extra_q, extra_d;
  code_entry_t         entry_q, entry_d;

  logic [5:0]  shift_q [MAX_STREAMS];
  logic [63:0] last_q  [MAX_STREAMS];

  logic        do_adv, do_fin, do_rej;
  logic [2:0]  adv_from;
  logic [1:0]  rej_kind;
  code_entry_t e;
  logic [63:0] acc_v;
  logic [7:0]  byte_v;
  logic [63:0] last_v, top_v, mask_v, delta_v, pts_v, lsb_v;
  logic [5:0]  sh_v;
  logic [47:0] prod_v;
  logic [48:0] sum_v;
  logic [31:0] len_v;
  logic [3:0]  extra_dec;
  fhp_in_t     it;

  assign it     = step_i.item;
  assign byte_v = it.data_byte;
  assign acc_v  = {acc_q[56:0], byte_v[6:0] & VARINT_DATA};

  always_comb begin
    phase_d    = phase_q;
    acc_d      = acc_q;
    code_d     = code_q;
    stream_d   = stream_q;
    pend_pts_d = pend_pts_q;
    pend_lsb_d = pend_lsb_q;
    extra_d    = extra_q;
    entry_d    = entry_q;
    e          = entry_q;
    do_adv     = 1'b0;
    adv_from   = PH_PTS;
    do_fin     = 1'b0;
    do_rej     = 1'b0;
    rej_kind   = KIND_NON_FRAME;
    extra_dec  = extra_q - 4'd1;

    if (step_i.go) begin
      case (it.mode)
        MODE_CODE_LOAD: begin
          if (it.entry_index == code_q) entry_d = to_entry(it);
        end
        MODE_BYTE: begin
          if (phase_q == PH_IDLE) begin
            e          = rd_entry_i;
            entry_d    = rd_entry_i;
            code_d     = byte_v;
            pend_pts_d = '0;
            pend_lsb_d = '0;
            acc_d      = '0;
            if (byte_v == NOT_FRAME_BYTE || e.flags[2]) begin
              do_rej   = 1'b1;
              rej_kind = KIND_NON_FRAME;
            end else if (e.stream_plus_one == '0) begin
              phase_d = PH_STREAM;
            end else if (e.stream_plus_one > 5'(MAX_STREAMS)) begin
              do_rej   = 1'b1;
              rej_kind = KIND_BAD_STREAM;
            end else begin
              stream_d = STREAM_W'(e.stream_plus_one - 5'd1);
              do_adv   = 1'b1;
              adv_from = PH_PTS;
            end
          end else if ((byte_v & VARINT_CONT) != '0) begin
            acc_d = acc_v;
          end else begin
            acc_d = '0;
            unique case (phase_q)
              PH_STREAM: begin
                if (acc_v >= 64'(MAX_STREAMS)) begin
                  do_rej   = 1'b1;
                  rej_kind = KIND_BAD_STREAM;
                end else begin
                  stream_d = acc_v[STREAM_W-1:0];
                  do_adv   = 1'b1;
                  adv_from = PH_PTS;
                end
              end
              PH_PTS: begin
                pend_pts_d = acc_v;
                do_adv     = 1'b1;
                adv_from   = PH_SIZE;
              end
              PH_SIZE: begin
                pend_lsb_d = acc_v;
                do_adv     = 1'b1;
                adv_from   = PH_EXTRA;
              end
              default: begin
                extra_d = extra_dec;
                do_fin  = (extra_dec == '0);
              end
            endcase
          end
        end
        default: ;
      endcase
    end

    if (do_adv) begin
      if (adv_from <= PH_PTS && e.pts_step == '0) begin
        phase_d = PH_PTS;
      end else if (adv_from <= PH_SIZE && e.flags[0]) begin
        phase_d = PH_SIZE;
      end else if (e.extra_fields != '0) begin
        extra_d = e.extra_fields;
        phase_d = PH_EXTRA;
      end else begin
        do_fin = 1'b1;
      end
    end

    last_v  = last_q[stream_d];
    sh_v    = shift_q[stream_d];
    top_v   = 64'd1 << sh_v;
    mask_v  = top_v - 64'd1;
    delta_v = last_v - (mask_v >> 1);
    if (e.pts_step != '0) begin
      pts_v = last_v + {{48{e.pts_step[15]}}, e.pts_step};
    end else if (pend_pts_d >= top_v) begin
      pts_v = pend_pts_d - top_v;
    end else begin
      pts_v = ((pend_pts_d - delta_v) & mask_v) + delta_v;
    end

    lsb_v  = e.flags[0] ? pend_lsb_d : '0;
    prod_v = 48'(lsb_v[31:0]) * 48'(e.multiplier);
    sum_v  = 49'(prod_v) + 49'(e.size_base);
    if ((lsb_v[63:32] != '0 && e.multiplier != '0) || sum_v[48:32] != '0) begin
      len_v = LEN_MAX;
    end else begin
      len_v = sum_v[31:0];
    end

    if (do_fin || do_rej) phase_d = PH_IDLE;
    if (do_rej) acc_d = '0;

    res_o.valid             = do_fin || do_rej;
    res_o.data.kind         = do_rej ? rej_kind : KIND_FRAME;
    res_o.data.start_code   = code_d;
    res_o.data.stream_id    = do_rej ? '0 : 4'(stream_d);
    res_o.data.frame_pts    = do_rej ? '0 : pts_v;
    res_o.data.frame_length = do_rej ? '0 : len_v;
    res_o.data.is_keyframe  = do_rej ? 1'b0 : e.flags[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      acc_q      <= '0;
      code_q     <= '0;
      stream_q   <= '0;
      pend_pts_q <= '0;
      pend_lsb_q <= '0;
      extra_q    <= '0;
    end else begin
      phase_q    <= phase_d;
      acc_q      <= acc_d;
      code_q     <= code_d;
      stream_q   <= stream_d;
      pend_pts_q <= pend_pts_d;
      pend_lsb_q <= pend_lsb_d;
      extra_q    <= extra_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (step_i.go && it.mode == MODE_STREAM_LOAD &&
        {1'b0, it.entry_index} < 9'(MAX_STREAMS)) begin
      shift_q[it.entry_index[STREAM_W-1:0]] <= it.stream_shift;
      last_q[it.entry_index[STREAM_W-1:0]]  <= it.stream_start_pts;
    end else if (do_fin) begin
      last_q[stream_d] <= pts_v;
    end
  end

  a_rej_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |=> phase_q == PH_IDLE)
    else $error("parser not idle after a result");

  a_res_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> step_i.go && it.mode == MODE_BYTE)
    else $error("result without a stream byte");

  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> acc_q == '0)
    else $error("varint accumulator dirty while idle");

endmodule

FILE: test/frame_header_parser_tb.sv
// ----------------------------------------------------------------------------
// frame_header_parser_tb
// Self-checking bench for the frame header parser. It fills the code and
// stream tables, runs directed headers over the edge cases, then random
// headers with table reloads, noise bytes and idle gaps on both channels. A
// scoreboard rebuilds every header result and compares each transaction on
// the output channel field by field.
// ----------------------------------------------------------------------------
module frame_header_parser_tb;
  import fhp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED   = 2'd3;
  localparam logic [7:0] CODE_FULL     = 8'h00;
  localparam logic [7:0] CODE_NONFRAME = 8'h01;
  localparam logic [7:0] CODE_BADFIX   = 8'h02;
  localparam logic [7:0] CODE_FIXED    = 8'hFF;
  localparam int RANDOM_ITEMS   = 1130;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef enum logic [2:0] {PH_IDLE, PH_STREAM, PH_PTS, PH_SIZE, PH_EXTRA} parse_phase_e;

  class header_scoreboard;
    code_entry_t  codes [FRAME_CODES];
    logic [5:0]   shifts [MAX_STREAMS];
    logic [63:0]  pts_hist [MAX_STREAMS];
    parse_phase_e phase;
    logic [63:0]  acc;
    logic [7:0]   cur_code;
    logic [3:0]   cur_stream;
    logic [63:0]  pend_pts;
    logic [63:0]  pend_size;
    logic [3:0]   extra_left;
    fhp_out_t     pending_headers [$];
    int           errors;

    function new();
      phase      = PH_IDLE;
      acc        = '0;
      cur_code   = '0;
      cur_stream = '0;
      pend_pts   = '0;
      pend_size  = '0;
      extra_left = '0;
      errors     = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("mismatch: %s", msg);
    endtask

    function void close_header();
      code_entry_t e;
      logic [63:0] prev;
      logic [63:0] pts;
      logic [63:0] top;
      logic [63:0] mask;
      logic [63:0] base_pts;
      logic [63:0] lsb_val;
      logic [95:0] wide;
      fhp_out_t    r;
      e    = codes[cur_code];
      prev = pts_hist[cur_stream];
      if (e.pts_step != 16'd0) begin
        pts = prev + {{48{e.pts_step[15]}}, e.pts_step};
      end else begin
        top = 64'd1 << shifts[cur_stream];
        if (pend_pts >= top) begin
          pts = pend_pts - top;
        end else begin
          mask     = top - 64'd1;
          base_pts = prev - (mask >> 1);
          pts      = ((pend_pts - base_pts) & mask) + base_pts;
        end
      end
      lsb_val = e.flags[0] ? pend_size : 64'd0;
      wide    = lsb_val * e.multiplier + e.size_base;
      pts_hist[cur_stream] = pts;
      phase = PH_IDLE;
      r.kind         = KIND_FRAME;
      r.start_code   = cur_code;
      r.stream_id    = cur_stream;
      r.frame_pts    = pts;
      r.frame_length = (wide > LEN_MAX) ? LEN_MAX : wide[31:0];
      r.is_keyframe  = e.flags[1];
      pending_headers.push_back(r);
    endfunction

    function void reject_header(logic [1:0] kind);
      fhp_out_t r;
      phase = PH_IDLE;
      acc   = '0;
      r     = '0;
      r.kind       = kind;
      r.start_code = cur_code;
      pending_headers.push_back(r);
    endfunction

    function void advance_to(parse_phase_e from);
      code_entry_t e;
      e = codes[cur_code];
      if (from <= PH_PTS && e.pts_step == 16'd0) begin
        phase = PH_PTS;
      end else if (from <= PH_SIZE && e.flags[0]) begin
        phase = PH_SIZE;
      end else if (e.extra_fields != 4'd0) begin
        extra_left = e.extra_fields;
        phase      = PH_EXTRA;
      end else begin
        close_header();
      end
    endfunction

    function void note_item(fhp_in_t it);
      code_entry_t e;
      logic [63:0] v;
      case (it.mode)
        MODE_CODE_LOAD: begin
          codes[it.entry_index] = '{flags: it.entry_flags,
                                    stream_plus_one: it.entry_stream_plus_one,
                                    multiplier: it.entry_multiplier,
                                    size_base: it.entry_size_base,
                                    pts_step: it.entry_pts_step,
                                    extra_fields: it.entry_extra_fields};
        end
        MODE_STREAM_LOAD: begin
          if (it.entry_index < MAX_STREAMS) begin
            shifts[it.entry_index[3:0]]   = it.stream_shift;
            pts_hist[it.entry_index[3:0]] = it.stream_start_pts;
          end
        end
        MODE_BYTE: begin
          if (phase == PH_IDLE) begin
            cur_code  = it.data_byte;
            e         = codes[cur_code];
            pend_pts  = '0;
            pend_size = '0;
            acc       = '0;
            if (cur_code == NOT_FRAME_BYTE || e.flags[2]) begin
              reject_header(KIND_NON_FRAME);
            end else if (e.stream_plus_one == 5'd0) begin
              phase = PH_STREAM;
            end else if (e.stream_plus_one > MAX_STREAMS) begin
              reject_header(KIND_BAD_STREAM);
            end else begin
              cur_stream = 4'(e.stream_plus_one - 5'd1);
              advance_to(PH_PTS);
            end
          end else begin
            acc = (acc << 7) | 64'(it.data_byte & {1'b0, VARINT_DATA});
            if ((it.data_byte & VARINT_CONT) == 8'd0) begin
              v   = acc;
              acc = '0;
              case (phase)
                PH_STREAM: begin
                  if (v >= MAX_STREAMS) begin
                    reject_header(KIND_BAD_STREAM);
                  end else begin
                    cur_stream = v[3:0];
                    advance_to(PH_PTS);
                  end
                end
                PH_PTS: begin
                  pend_pts = v;
                  advance_to(PH_SIZE);
                end
                PH_SIZE: begin
                  pend_size = v;
                  advance_to(PH_EXTRA);
                end
                default: begin
                  extra_left = extra_left - 4'd1;
                  if (extra_left == 4'd0) close_header();
                end
              endcase
            end
          end
        end
        default: ;
      endcase
    endfunction

    task check_header(fhp_out_t got);
      fhp_out_t want;
      if (pending_headers.size() == 0) begin
        report($sformatf("unexpected header, code %02h kind %0d", got.start_code, got.kind));
        return;
      end
      want = pending_headers.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.start_code !== want.start_code)
        report($sformatf("start_code %02h, want %02h", got.start_code, want.start_code));
      if (got.stream_id !== want.stream_id)
        report($sformatf("stream_id %0d, want %0d", got.stream_id, want.stream_id));
      if (got.frame_pts !== want.frame_pts)
        report($sformatf("frame_pts %016h, want %016h", got.frame_pts, want.frame_pts));
      if (got.frame_length !== want.frame_length)
        report($sformatf("frame_length %08h, want %08h", got.frame_length,
                         want.frame_length));
      if (got.is_keyframe !== want.is_keyframe)
        report($sformatf("is_keyframe %0b, want %0b", got.is_keyframe, want.is_keyframe));
    endtask
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  fhp_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  fhp_out_t out_data_o;

  header_scoreboard sb = new();
  code_entry_t plan_codes [FRAME_CODES];
  int  sent_items;
  int  idle_cycles;
  int  hold_left;
  bit  steady;

  frame_header_parser DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] varint_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 64'd0;
    if (r == 1) return '1;
    if (r == 2) return rand64();
    return rand64() >> $urandom_range(0, 63);
  endfunction

  function automatic fhp_in_t noise_item();
    logic [159:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return fhp_in_t'(bits[$bits(fhp_in_t)-1:0]);
  endfunction

  function automatic code_entry_t random_entry();
    code_entry_t e;
    int r;
    e.flags = {$urandom_range(0, 6) == 0, 2'($urandom_range(0, 3))};
    r = $urandom_range(0, 99);
    if (r < 40) e.stream_plus_one = 5'd0;
    else if (r < 85) e.stream_plus_one = 5'($urandom_range(1, 16));
    else e.stream_plus_one = 5'($urandom_range(17, 31));
    r = $urandom_range(0, 9);
    e.multiplier = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom);
    e.size_base = 17'($urandom);
    r = $urandom_range(0, 9);
    if (r < 5) e.pts_step = 16'd0;
    else if (r == 5) e.pts_step = 16'h8000;
    else if (r == 6) e.pts_step = 16'h7FFF;
    else e.pts_step = 16'($urandom);
    r = $urandom_range(0, 9);
    if (r < 6) e.extra_fields = 4'd0;
    else if (r < 9) e.extra_fields = 4'($urandom_range(1, 3));
    else e.extra_fields = 4'($urandom_range(4, 15));
    return e;
  endfunction

  // Offer one transaction on the input channel and hold it until accepted.
  task automatic send_item(fhp_in_t it);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i  = it;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (!(it.mode == MODE_UNUSED ||
          (it.mode == MODE_STREAM_LOAD && it.entry_index >= MAX_STREAMS)))
      sent_items++;
  endtask

  task automatic send_byte(logic [7:0] b);
    fhp_in_t it;
    it           = noise_item();
    it.mode      = MODE_BYTE;
    it.data_byte = b;
    send_item(it);
  endtask

  task automatic send_code_load(logic [7:0] idx, code_entry_t e);
    fhp_in_t it;
    it                       = noise_item();
    it.mode                  = MODE_CODE_LOAD;
    it.entry_index           = idx;
    it.entry_flags           = e.flags;
    it.entry_stream_plus_one = e.stream_plus_one;
    it.entry_multiplier      = e.multiplier;
    it.entry_size_base       = e.size_base;
    it.entry_pts_step        = e.pts_step;
    it.entry_extra_fields    = e.extra_fields;
    plan_codes[idx]          = e;
    send_item(it);
  endtask

  task automatic send_stream_load(logic [7:0] idx, logic [5:0] shift, logic [63:0] start);
    fhp_in_t it;
    it                  = noise_item();
    it.mode             = MODE_STREAM_LOAD;
    it.entry_index      = idx;
    it.stream_shift     = shift;
    it.stream_start_pts = start;
    send_item(it);
  endtask

  task automatic send_varint(logic [83:0] v, int pad);
    int groups;
    groups = 1;
    while (groups < 12 && (v >> (7 * groups)) != 84'd0) groups++;
    groups += pad;
    for (int i = groups - 1; i >= 0; i--)
      send_byte((8'(v >> (7 * i)) & {1'b0, VARINT_DATA}) |
                ((i != 0) ? VARINT_CONT : 8'h00));
  endtask

  task automatic send_field(logic [63:0] v);
    int r;
    logic [95:0] wide;
    r = $urandom_range(0, 19);
    wide = {$urandom, $urandom, $urandom};
    if (r == 0) send_varint(wide[83:0], 0);
    else if (r < 3) send_varint({20'd0, v}, $urandom_range(1, 2));
    else send_varint({20'd0, v}, 0);
  endtask

  task automatic stir_tables(int odds);
    int r;
    fhp_in_t it;
    if ($urandom_range(0, odds - 1) != 0) return;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      send_code_load(8'($urandom), random_entry());
    end else if (r < 85) begin
      send_stream_load(($urandom_range(0, 4) == 0) ? 8'($urandom_range(16, 255))
                                                   : 8'($urandom_range(0, 15)),
                       6'($urandom), ($urandom_range(0, 5) == 0) ? '1 : rand64());
    end else begin
      it      = noise_item();
      it.mode = MODE_UNUSED;
      send_item(it);
    end
  endtask

  task automatic send_header(logic [7:0] code);
    code_entry_t e;
    logic [63:0] v;
    e = plan_codes[code];
    send_byte(code);
    if (code == NOT_FRAME_BYTE || e.flags[2]) return;
    if (e.stream_plus_one == 5'd0) begin
      stir_tables(16);
      v = ($urandom_range(0, 9) == 0) ? varint_value() : 64'($urandom_range(0, 15));
      send_field(v);
      if (v >= MAX_STREAMS) return;
    end else if (e.stream_plus_one > MAX_STREAMS) begin
      return;
    end
    if (e.pts_step == 16'd0) begin
      stir_tables(16);
      send_field(varint_value());
    end
    if (e.flags[0]) begin
      stir_tables(16);
      send_field(varint_value());
    end
    repeat (e.extra_fields) begin
      stir_tables(16);
      send_field(varint_value());
    end
  endtask

  // Drop valid and hold the sender until every expected header has arrived.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending_headers.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : monitor
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && in_ready_o) begin
        sb.note_item(in_data_i);
        moved = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_header(out_data_o);
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) @(negedge clk_i);
    $display("FAIL frame_header_parser");
    $finish;
  end

  initial begin : receiver
    int stall_left;
    stall_left  = 0;
    hold_left   = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else begin
        out_ready_i = 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    code_entry_t e;
    int  r;
    int  hdr_count;
    bit  held;
    fhp_in_t it;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    steady     = 1'b0;
    sent_items = 0;
    hdr_count  = 0;
    held       = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Fill every table entry before any header can read it.
    for (int i = 0; i < FRAME_CODES; i++) begin
      e = random_entry();
      case (8'(i))
        CODE_FULL:     e = '{flags: 3'b011, stream_plus_one: 5'd0, multiplier: 16'hFFFF,
                             size_base: 17'h1FFFF, pts_step: 16'd0, extra_fields: 4'd2};
        CODE_NONFRAME: e.flags[2] = 1'b1;
        CODE_BADFIX:   e = '{flags: 3'b000, stream_plus_one: 5'd31, multiplier: 16'd1,
                             size_base: 17'd0, pts_step: 16'd0, extra_fields: 4'd0};
        CODE_FIXED:    e = '{flags: 3'b010, stream_plus_one: 5'd16, multiplier: 16'd0,
                             size_base: 17'd0, pts_step: 16'h8000, extra_fields: 4'd0};
        NOT_FRAME_BYTE: e.flags[2] = 1'b0;
        default: ;
      endcase
      send_code_load(8'(i), e);
    end
    for (int i = 0; i < MAX_STREAMS; i++)
      send_stream_load(8'(i), (i == 0) ? 6'd0 : (i == 1) ? 6'd62 : (i == 15) ? 6'd63
                                                          : 6'($urandom),
                       (i == 0) ? 64'd0 : (i == 15) ? '1 : rand64());
    send_stream_load(8'd16, 6'd5, 64'd0);
    send_stream_load(8'd255, 6'd5, 64'd0);
    wait_drained();

    // Directed headers: rejects, fixed fields, long varints, loads mid-header.
    send_byte(NOT_FRAME_BYTE);
    send_byte(CODE_NONFRAME);
    send_byte(CODE_BADFIX);
    send_byte(CODE_FULL);
    send_varint(84'd16, 0);
    send_byte(CODE_FIXED);
    send_byte(CODE_FULL);
    send_varint(84'd15, 1);
    it      = noise_item();
    it.mode = MODE_UNUSED;
    send_item(it);
    send_stream_load(8'd200, 6'd1, 64'd1);
    send_varint('1, 0);
    send_code_load(8'h10, random_entry());
    send_varint({20'd0, 64'hFFFF_FFFF_FFFF_FFFF}, 0);
    send_varint(84'd0, 0);
    send_varint(84'h7F, 0);
    send_byte(CODE_FULL);
    send_varint(84'd0, 0);
    send_varint(84'd0, 0);
    send_varint(84'd0, 0);
    send_varint(84'd0, 0);
    send_varint(84'd1, 0);
    send_byte(CODE_FULL);
    send_varint(84'd1, 0);
    send_varint(84'd1, 0);
    send_varint(84'd1, 0);
    send_varint(84'hFF, 0);
    send_varint(84'd0, 0);
    wait_drained();

    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      steady = ((hdr_count / 40) % 4) == 2;
      if (hdr_count == 60 && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      r = $urandom_range(0, 99);
      if (r < 84) begin
        send_header(($urandom_range(0, 19) == 0) ? NOT_FRAME_BYTE : 8'($urandom));
        hdr_count++;
      end else if (r < 92) begin
        stir_tables(1);
      end else if (r < 97) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end else begin
        wait_drained();
      end
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("PASS frame_header_parser");
    end else begin
      $display("FAIL frame_header_parser");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/fhp_pkg.sv
hw/rtl/fhp_parser.sv
hw/rtl/frame_header_parser.sv
test/frame_header_parser_tb.sv
